// ===== sv/plcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_pkg
// Types and constants for the piecewise linear color ramp.
// ----------------------------------------------------------------------------
package plcr_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int TABLE_SHIFT   = $clog2(TABLE_ENTRIES);

    localparam int NUM_POINTS = 5;
    localparam int NUM_CH     = 4;
    localparam int VAL_W      = 16;
    localparam int CH_W       = 8;
    localparam int IDX_W      = 9;
    localparam int PROD_W     = IDX_W + VAL_W;
    localparam int NUM_W      = CH_W + VAL_W;
    localparam int DIV_STEPS  = CH_W;
    localparam int CFG_IDX_W  = 3;
    localparam int PT_W       = VAL_W + NUM_CH * CH_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    // Channel 0 is red, then green, blue and alpha.
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] color;
        logic [VAL_W-1:0]            value;
    } t_point;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_VALUE   = 3'd0,
        REG_MAX_VALUE   = 3'd1,
        REG_POINT_ZERO  = 3'd2,
        REG_POINT_ONE   = 3'd3,
        REG_POINT_TWO   = 3'd4,
        REG_POINT_THREE = 3'd5,
        REG_POINT_FOUR  = 3'd6
    } t_cfg_reg;

    localparam logic [VAL_W-1:0] MIN_RESET = 16'd0;
    localparam logic [VAL_W-1:0] MAX_RESET = 16'd4095;

    localparam logic [NUM_POINTS-1:0][PT_W-1:0] POINT_RESET = {
        48'd281474254375364,
        48'd877471859830,
        48'd85759759483752,
        48'd168225582219576,
        48'd164
    };

endpackage

// ===== sv/piecewise_linear_color_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp
// Computes one RGBA8 transfer-function table entry per beat by linear
// interpolation between five programmable control points.
// ----------------------------------------------------------------------------
// The block takes one table index per clock cycle and returns one RGBA8 entry
// per cycle while the output is not stalled, in order. The entry is built up
// in the pipeline: span, index multiply, data value, segment search, segment
// offsets, channel products, rounding sum, and an eight-stage restoring divider
// that yields one quotient bit per stage for all four channels. When the output
// is stalled the pipeline fills its empty stages and then holds. Configuration
// is written through its own channel, which is always ready; write it only
// while no entry is in flight.

module piecewise_linear_color_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // entry_index[8:0], zero pad
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // entry_out[8:0], red, green, blue, alpha, zero pad
);

    localparam int NSTG = 7 + plcr_pkg::DIV_STEPS;
    localparam int LAST = NSTG - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [plcr_pkg::VAL_W-1:0] r_min;
    logic [plcr_pkg::VAL_W-1:0] r_max;
    plcr_pkg::t_point           r_point [plcr_pkg::NUM_POINTS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= plcr_pkg::MIN_RESET;
            r_max <= plcr_pkg::MAX_RESET;
            for (int i = 0; i < plcr_pkg::NUM_POINTS; i++) begin
                r_point[i] <= plcr_pkg::t_point'(plcr_pkg::POINT_RESET[i]);
            end
        end else if (i_cfg_valid) begin
            case (plcr_pkg::t_cfg_reg'(i_cfg_index))
                plcr_pkg::REG_MIN_VALUE:   r_min <= i_cfg_data[plcr_pkg::VAL_W-1:0];
                plcr_pkg::REG_MAX_VALUE:   r_max <= i_cfg_data[plcr_pkg::VAL_W-1:0];
                plcr_pkg::REG_POINT_ZERO:  r_point[0] <= plcr_pkg::t_point'(i_cfg_data);
                plcr_pkg::REG_POINT_ONE:   r_point[1] <= plcr_pkg::t_point'(i_cfg_data);
                plcr_pkg::REG_POINT_TWO:   r_point[2] <= plcr_pkg::t_point'(i_cfg_data);
                plcr_pkg::REG_POINT_THREE: r_point[3] <= plcr_pkg::t_point'(i_cfg_data);
                plcr_pkg::REG_POINT_FOUR:  r_point[4] <= plcr_pkg::t_point'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and advance chain
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[LAST] = !r_vld[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: span. Stage 1: index times span. Stage 2: data value.
    // ------------------------------------------------------------------
    logic [plcr_pkg::IDX_W-1:0]  r0_idx, r1_idx, r2_idx, r3_idx, r4_idx, r5_idx, r6_idx;
    logic [plcr_pkg::VAL_W-1:0]  r0_span;
    logic [plcr_pkg::PROD_W-1:0] r1_prod;
    logic [plcr_pkg::VAL_W-1:0]  r2_v;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_idx  <= s_axis_tdata[plcr_pkg::IDX_W-1:0];
            r0_span <= (r_max >= r_min) ? (r_max - r_min) : '0;
        end
        if (adv[1]) begin
            r1_idx  <= r0_idx;
            r1_prod <= plcr_pkg::PROD_W'(r0_idx) * plcr_pkg::PROD_W'(r0_span);
        end
        if (adv[2]) begin
            r2_idx <= r1_idx;
            // The quotient stays below the span, so the sum fits 16 bits.
            r2_v   <= r_min + plcr_pkg::VAL_W'(r1_prod >> plcr_pkg::TABLE_SHIFT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: segment search over the control points.
    // ------------------------------------------------------------------
    plcr_pkg::t_point prev_pt [plcr_pkg::NUM_POINTS];
    plcr_pkg::t_point n3_lo, n3_hi;
    logic             n3_found;

    always_comb begin
        prev_pt[0].value = r_min;
        prev_pt[0].color = '0;
        for (int i = 1; i < plcr_pkg::NUM_POINTS; i++) begin
            prev_pt[i] = r_point[i-1];
        end
    end

    always_comb begin
        n3_found = 1'b0;
        n3_lo    = r_point[plcr_pkg::NUM_POINTS-1];
        n3_hi    = r_point[plcr_pkg::NUM_POINTS-1];
        for (int i = 0; i < plcr_pkg::NUM_POINTS; i++) begin
            if (!n3_found && (r_point[i].value >= r2_v)) begin
                n3_found = 1'b1;
                n3_lo    = prev_pt[i];
                n3_hi    = r_point[i];
            end
        end
    end

    logic [plcr_pkg::VAL_W-1:0] r3_v;
    plcr_pkg::t_point           r3_lo, r3_hi;
    logic                       r3_beyond;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_idx    <= r2_idx;
            r3_v      <= r2_v;
            r3_lo     <= n3_lo;
            r3_hi     <= n3_hi;
            r3_beyond <= !n3_found;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: segment offsets. Past the last point or on an empty segment
    // the divisor is forced to one so the upper color passes through.
    // ------------------------------------------------------------------
    logic                                 pass4;
    logic [plcr_pkg::VAL_W-1:0]           r4_d, r4_n, r4_dn;
    logic [plcr_pkg::NUM_CH-1:0][plcr_pkg::CH_W-1:0] r4_lo_c, r4_hi_c;

    assign pass4 = r3_beyond || (r3_hi.value == r3_lo.value);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_idx  <= r3_idx;
            r4_hi_c <= r3_hi.color;
            if (pass4) begin
                r4_d    <= plcr_pkg::VAL_W'(1);
                r4_n    <= '0;
                r4_dn   <= plcr_pkg::VAL_W'(1);
                r4_lo_c <= r3_hi.color;
            end else begin
                r4_d    <= r3_hi.value - r3_lo.value;
                r4_n    <= r3_v - r3_lo.value;
                r4_dn   <= r3_hi.value - r3_v;
                r4_lo_c <= r3_lo.color;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: channel products. Stage 6: rounded numerator.
    // ------------------------------------------------------------------
    logic [plcr_pkg::VAL_W-1:0] r5_d, r6_d;
    logic [plcr_pkg::NUM_W-1:0] r5_plo [plcr_pkg::NUM_CH];
    logic [plcr_pkg::NUM_W-1:0] r5_phi [plcr_pkg::NUM_CH];
    logic [plcr_pkg::NUM_W-1:0] r6_num [plcr_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_idx <= r4_idx;
            r5_d   <= r4_d;
            for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                r5_plo[c] <= plcr_pkg::NUM_W'(r4_lo_c[c]) * plcr_pkg::NUM_W'(r4_dn);
                r5_phi[c] <= plcr_pkg::NUM_W'(r4_hi_c[c]) * plcr_pkg::NUM_W'(r4_n);
            end
        end
        if (adv[6]) begin
            r6_idx <= r5_idx;
            r6_d   <= r5_d;
            // Bounded by 255 * d + d / 2, which fits the numerator width.
            for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                r6_num[c] <= r5_plo[c] + r5_phi[c] + plcr_pkg::NUM_W'(r5_d >> 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 7 to 14: restoring divider, one quotient bit per stage, MSB
    // first. The quotient never exceeds eight bits.
    // ------------------------------------------------------------------
    localparam int DS = plcr_pkg::DIV_STEPS;

    logic [plcr_pkg::NUM_W-1:0] r_drem [DS-1][plcr_pkg::NUM_CH];
    logic [plcr_pkg::VAL_W-1:0] r_dden [DS-1];
    logic [plcr_pkg::CH_W-1:0]  r_dq   [DS][plcr_pkg::NUM_CH];
    logic [plcr_pkg::IDX_W-1:0] r_didx [DS];

    logic [plcr_pkg::NUM_W-1:0] d_rem_in [DS][plcr_pkg::NUM_CH];
    logic [plcr_pkg::CH_W-1:0]  d_q_in   [DS][plcr_pkg::NUM_CH];
    logic [plcr_pkg::VAL_W-1:0] d_den_in [DS];
    logic [plcr_pkg::IDX_W-1:0] d_idx_in [DS];
    logic [plcr_pkg::NUM_W-1:0] d_rem_nx [DS][plcr_pkg::NUM_CH];
    logic [plcr_pkg::CH_W-1:0]  d_q_nx   [DS][plcr_pkg::NUM_CH];

    always_comb begin
        d_den_in[0] = r6_d;
        d_idx_in[0] = r6_idx;
        for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
            d_rem_in[0][c] = r6_num[c];
            d_q_in[0][c]   = '0;
        end
        for (int j = 1; j < DS; j++) begin
            d_den_in[j] = r_dden[j-1];
            d_idx_in[j] = r_didx[j-1];
            for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                d_rem_in[j][c] = r_drem[j-1][c];
                d_q_in[j][c]   = r_dq[j-1][c];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < DS; j++) begin
            for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                logic [plcr_pkg::NUM_W-1:0] dsh;
                dsh = plcr_pkg::NUM_W'(d_den_in[j]) << (DS - 1 - j);
                d_q_nx[j][c] = d_q_in[j][c];
                if (d_rem_in[j][c] >= dsh) begin
                    d_rem_nx[j][c]             = d_rem_in[j][c] - dsh;
                    d_q_nx[j][c][DS - 1 - j]   = 1'b1;
                end else begin
                    d_rem_nx[j][c]             = d_rem_in[j][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DS; j++) begin
            if (adv[7 + j]) begin
                r_didx[j] <= d_idx_in[j];
                for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                    r_dq[j][c] <= d_q_nx[j][c];
                end
                if (j < DS - 1) begin
                    r_dden[j] <= d_den_in[j];
                    for (int c = 0; c < plcr_pkg::NUM_CH; c++) begin
                        r_drem[j][c] <= d_rem_nx[j][c];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = {7'd0,
                            r_dq[DS-1][3], r_dq[DS-1][2], r_dq[DS-1][1], r_dq[DS-1][0],
                            r_didx[DS-1]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat did not enter the first stage");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input blocked while the pipeline has an empty stage");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r4_d != '0))
        else $error("zero divisor reached the divider");

    a_offsets_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> ((17'(r4_n) + 17'(r4_dn)) == 17'(r4_d)))
        else $error("segment offsets do not add up to the segment width");

endmodule

// ===== sim/plcr_ramp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_ramp_checker
// Watches the configuration, input and result channels of the color ramp,
// keeps its own copy of the ramp registers, predicts every table entry and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module plcr_ramp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [plcr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plcr_pkg::PT_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [plcr_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [plcr_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                               o_entries_in_flight,
    output int                               o_mismatches
);

    typedef struct packed {
        logic [plcr_pkg::IDX_W-1:0]                      entry;
        logic [plcr_pkg::NUM_CH-1:0][plcr_pkg::CH_W-1:0] rgba;
    } t_ramp_result;

    localparam int REPORT_LIMIT = 10;

    string channel_name [plcr_pkg::NUM_CH] = '{"red", "green", "blue", "alpha"};

    logic [plcr_pkg::VAL_W-1:0] ramp_lo;
    logic [plcr_pkg::VAL_W-1:0] ramp_hi;
    plcr_pkg::t_point           ctrl_pt [plcr_pkg::NUM_POINTS];
    t_ramp_result               expected_entries [$];

    initial begin
        o_entries_in_flight = 0;
        o_mismatches        = 0;
    end

    // Data value of the entry, then exact interpolation inside the first
    // segment whose upper point reaches that value, rounded half up.
    function automatic t_ramp_result ramp_entry(input logic [plcr_pkg::IDX_W-1:0] idx);
        longint unsigned span, v, lo_v, hi_v, d, n, lo_c, hi_c, c;
        int              seg;
        t_ramp_result    r;
        span = (ramp_hi >= ramp_lo) ? longint'(ramp_hi) - longint'(ramp_lo) : 0;
        v    = ramp_lo + (idx * span) / plcr_pkg::TABLE_ENTRIES;
        seg  = plcr_pkg::NUM_POINTS;
        for (int i = plcr_pkg::NUM_POINTS - 1; i >= 0; i--) begin
            if (ctrl_pt[i].value >= v) seg = i;
        end
        r.entry = idx;
        if (seg == plcr_pkg::NUM_POINTS) begin
            r.rgba = ctrl_pt[plcr_pkg::NUM_POINTS-1].color;
        end else begin
            lo_v = (seg == 0) ? ramp_lo : ctrl_pt[seg-1].value;
            hi_v = ctrl_pt[seg].value;
            d    = hi_v - lo_v;
            n    = v - lo_v;
            for (int ch = 0; ch < plcr_pkg::NUM_CH; ch++) begin
                lo_c = (seg == 0) ? 0 : ctrl_pt[seg-1].color[ch];
                hi_c = ctrl_pt[seg].color[ch];
                if (d == 0) c = hi_c;
                else c = (lo_c * (d - n) + hi_c * n + d / 2) / d;
                r.rgba[ch] = c[plcr_pkg::CH_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got, input int unsigned entry);
        if (want !== got) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("%0t: entry %0d %s expected %0d got %0d",
                         $realtime, entry, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_ramp_result want;
        if (!i_rst_n) begin
            ramp_lo = plcr_pkg::MIN_RESET;
            ramp_hi = plcr_pkg::MAX_RESET;
            for (int i = 0; i < plcr_pkg::NUM_POINTS; i++)
                ctrl_pt[i] = plcr_pkg::POINT_RESET[i];
            expected_entries.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    plcr_pkg::REG_MIN_VALUE: ramp_lo = i_cfg_data[plcr_pkg::VAL_W-1:0];
                    plcr_pkg::REG_MAX_VALUE: ramp_hi = i_cfg_data[plcr_pkg::VAL_W-1:0];
                    plcr_pkg::REG_POINT_ZERO, plcr_pkg::REG_POINT_ONE,
                    plcr_pkg::REG_POINT_TWO, plcr_pkg::REG_POINT_THREE,
                    plcr_pkg::REG_POINT_FOUR:
                        ctrl_pt[i_cfg_index - plcr_pkg::REG_POINT_ZERO] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_entries.insert(expected_entries.size(),
                                        ramp_entry(i_in_data[plcr_pkg::IDX_W-1:0]));
            if (i_out_valid && i_out_ready) begin
                if (expected_entries.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result beat, tdata %h",
                                 $realtime, i_out_data);
                end else begin
                    want = expected_entries.pop_front();
                    check_field("entry", want.entry, i_out_data[plcr_pkg::IDX_W-1:0],
                                want.entry);
                    for (int ch = 0; ch < plcr_pkg::NUM_CH; ch++)
                        check_field(channel_name[ch], want.rgba[ch],
                                    i_out_data[plcr_pkg::IDX_W + plcr_pkg::CH_W*ch +:
                                               plcr_pkg::CH_W],
                                    want.entry);
                end
            end
        end
        o_entries_in_flight <= expected_entries.size();
    end

endmodule

// ===== sim/piecewise_linear_color_ramp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp_tb
// Drives table indices through the color ramp under a series of ramp settings,
// directed corner settings first and then random ones, with random gaps on
// the input in most phases and random back-pressure on the output. A checker
// predicts every entry; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module piecewise_linear_color_ramp_tb;

    localparam int LATENCY       = 15;
    localparam int LONG_STALL    = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [plcr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic [plcr_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [plcr_pkg::PT_W-1:0]        i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic [plcr_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tready = 1'b0;
    logic                             o_cfg_ready;
    logic                             s_axis_tready;
    logic                             m_axis_tvalid;
    logic [plcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int entries_in_flight;
    int mismatches;
    int cycle_count = 0;
    int stall_token = 0;
    int stall_seen  = 0;
    int ready_left  = 0;
    bit gaps_on     = 1'b1;

    always #5 i_clk = ~i_clk;

    piecewise_linear_color_ramp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    plcr_ramp_checker ramp_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (s_axis_tvalid),
        .i_in_ready          (s_axis_tready),
        .i_in_data           (s_axis_tdata),
        .i_out_valid         (m_axis_tvalid),
        .i_out_ready         (m_axis_tready),
        .i_out_data          (m_axis_tdata),
        .o_entries_in_flight (entries_in_flight),
        .o_mismatches        (mismatches)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** piecewise_linear_color_ramp: FAILED **");
            $finish;
        end
    end

    // Output back-pressure: mostly ready in runs, short and long stalls, and a
    // long hold-off whenever the stimulus bumps the stall token.
    always @(posedge i_clk) begin : ready_pattern
        int roll;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_left    <= 0;
        end else if (stall_token != stall_seen) begin
            stall_seen    <= stall_token;
            m_axis_tready <= 1'b0;
            ready_left    <= LONG_STALL;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(0, (roll < 5) ? 60 : 20);
            end else if (roll < 92) begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(8, 40);
            end
        end
    end

    function automatic plcr_pkg::t_point make_point(
        input logic [plcr_pkg::VAL_W-1:0] value,
        input logic [plcr_pkg::CH_W-1:0] r, g, b, a);
        plcr_pkg::t_point p;
        p.value    = value;
        p.color[0] = r;
        p.color[1] = g;
        p.color[2] = b;
        p.color[3] = a;
        return p;
    endfunction

    function automatic logic [plcr_pkg::CH_W-1:0] rand_level();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return plcr_pkg::CH_W'($urandom_range(0, 255));
    endfunction

    // Leaves valid high; the caller lowers it once the batch of writes is done.
    task automatic write_reg(input logic [plcr_pkg::CFG_IDX_W-1:0] index,
                             input logic [plcr_pkg::PT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_ramp(input logic [plcr_pkg::VAL_W-1:0] lo,
                                input logic [plcr_pkg::VAL_W-1:0] hi,
                                input plcr_pkg::t_point p0, p1, p2, p3, p4);
        write_reg(plcr_pkg::REG_MIN_VALUE, plcr_pkg::PT_W'(lo));
        write_reg(plcr_pkg::REG_MAX_VALUE, plcr_pkg::PT_W'(hi));
        write_reg(plcr_pkg::REG_POINT_ZERO, p0);
        write_reg(plcr_pkg::REG_POINT_ONE, p1);
        write_reg(plcr_pkg::REG_POINT_TWO, p2);
        write_reg(plcr_pkg::REG_POINT_THREE, p3);
        write_reg(plcr_pkg::REG_POINT_FOUR, p4);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_entry(input logic [plcr_pkg::IDX_W-1:0] idx);
        int roll, gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= plcr_pkg::IN_TDATA_W'(idx);
        do @(posedge i_clk); while (!s_axis_tready);
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted entry has come back.
    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (entries_in_flight != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic random_ramp();
        int               lo, hi, span, style, k, tmp;
        int               vals [plcr_pkg::NUM_POINTS];
        plcr_pkg::t_point pts [plcr_pkg::NUM_POINTS];
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // Reversed range: every entry lands on the start value.
            lo = $urandom_range(1, 65535);
            hi = $urandom_range(0, lo - 1);
        end else if (style == 1) begin
            lo = 0;
            hi = 65535;
        end else if (style < 5) begin
            lo = $urandom_range(0, 65535);
            hi = lo + $urandom_range(0, (65535 - lo < 600) ? 65535 - lo : 600);
        end else begin
            lo = $urandom_range(0, 40000);
            hi = $urandom_range(lo, 65535);
        end
        span = (hi > lo) ? hi - lo : 0;
        foreach (vals[i]) begin
            if ($urandom_range(0, 7) == 0) begin
                vals[i] = $urandom_range(0, 65535);
            end else begin
                vals[i] = lo + $urandom_range(0, span + span / 4 + 2);
                if (vals[i] > 65535) vals[i] = 65535;
            end
        end
        if (style != 9) begin
            for (int a = 0; a < plcr_pkg::NUM_POINTS - 1; a++)
                for (int b = 0; b < plcr_pkg::NUM_POINTS - 1 - a; b++)
                    if (vals[b] > vals[b+1]) begin
                        tmp       = vals[b];
                        vals[b]   = vals[b+1];
                        vals[b+1] = tmp;
                    end
        end
        if ($urandom_range(0, 4) == 0) begin
            k         = $urandom_range(0, plcr_pkg::NUM_POINTS - 2);
            vals[k+1] = vals[k];
        end
        if ($urandom_range(0, 5) == 0) vals[0] = lo;
        foreach (pts[i])
            pts[i] = make_point(plcr_pkg::VAL_W'(vals[i]), rand_level(), rand_level(),
                                rand_level(), rand_level());
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, plcr_pkg::PT_W'({$urandom, $urandom}));
        program_ramp(plcr_pkg::VAL_W'(lo), plcr_pkg::VAL_W'(hi),
                     pts[0], pts[1], pts[2], pts[3], pts[4]);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ramp as it comes out of reset.
        send_entry(9'd0);   send_entry(9'd1);   send_entry(9'd256);
        send_entry(9'd511); send_entry(9'h155); send_entry(9'h0AA);
        end_burst();

        // Full data range, points at both ends, saturated colors. Entry zero
        // falls on a first point that sits exactly on the start value.
        program_ramp(16'd0, 16'd65535,
                     make_point(16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                     make_point(16'd16384, 8'h00, 8'h00, 8'h00, 8'h00),
                     make_point(16'd32768, 8'hFF, 8'h00, 8'hFF, 8'h00),
                     make_point(16'd49152, 8'h00, 8'hFF, 8'h00, 8'hFF),
                     make_point(16'd65535, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_entry(9'd0);   send_entry(9'd1);   send_entry(9'd128);
        send_entry(9'd255); send_entry(9'd384); send_entry(9'd511);
        end_burst();

        // Reversed range above every point: the last color holds.
        program_ramp(16'd65535, 16'd0,
                     make_point(16'd10, 8'h11, 8'h22, 8'h33, 8'h44),
                     make_point(16'd20, 8'h55, 8'h66, 8'h77, 8'h88),
                     make_point(16'd30, 8'h99, 8'hAA, 8'hBB, 8'hCC),
                     make_point(16'd40, 8'hDD, 8'hEE, 8'hFF, 8'h01),
                     make_point(16'd50, 8'h80, 8'h7F, 8'h01, 8'hFE));
        send_entry(9'd0); send_entry(9'd511);
        end_burst();

        // Reversed range landing on a zero-width first segment.
        program_ramp(16'd300, 16'd299,
                     make_point(16'd300, 8'hA5, 8'h5A, 8'h0F, 8'hF0),
                     make_point(16'd400, 8'h00, 8'h00, 8'h00, 8'h00),
                     make_point(16'd500, 8'h00, 8'h00, 8'h00, 8'h00),
                     make_point(16'd600, 8'h00, 8'h00, 8'h00, 8'h00),
                     make_point(16'd700, 8'h00, 8'h00, 8'h00, 8'h00));
        send_entry(9'd7); send_entry(9'd400);
        end_burst();

        // Points out of order, plus a write to an index with no register.
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        program_ramp(16'd0, 16'd65535,
                     make_point(16'd50000, 8'hFF, 8'h00, 8'h80, 8'h40),
                     make_point(16'd100, 8'h00, 8'hFF, 8'h10, 8'hC0),
                     make_point(16'd65535, 8'h20, 8'h30, 8'hFF, 8'h00),
                     make_point(16'd200, 8'h01, 8'h02, 8'h03, 8'h04),
                     make_point(16'd30000, 8'hFE, 8'hFD, 8'hFC, 8'hFB));
        send_entry(9'd0); send_entry(9'd100); send_entry(9'd300); send_entry(9'd450);
        end_burst();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_ramp();
            gaps_on = (phase % 3 != 1);
            // Back-to-back input against a long output hold-off fills the pipe.
            if (phase == 4) stall_token <= stall_token + 1;
            repeat (PHASE_ITEMS) send_entry(plcr_pkg::IDX_W'($urandom_range(0, 511)));
            end_burst();
        end

        if (mismatches == 0)
            $display("** piecewise_linear_color_ramp: PASSED **");
        else
            $display("** piecewise_linear_color_ramp: FAILED **");
        $finish;
    end

endmodule

// ===== piecewise_linear_color_ramp.f =====
sv/plcr_pkg.sv
sv/piecewise_linear_color_ramp.sv
sim/plcr_ramp_checker.sv
sim/piecewise_linear_color_ramp_tb.sv
